// ----- src/ddm_pkg.sv -----
// shared types and constants for the differential drive mixer
// no dependencies; imported by ddm_div, differential_drive_mixer and the testbench
package ddm_pkg;

	localparam int CMD_W     = 16;
	localparam int DRV_W     = 9;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 24;

	// data that rides alongside the quotient through the divider
	typedef struct packed {
		logic             byp;    // magnitude within limit, pass raw sums through
		logic             neg_l;
		logic             neg_r;
		logic [DRV_W-1:0] raw_l;
		logic [DRV_W-1:0] raw_r;
	} side_t;

endpackage

// ----- src/ddm_div.sv -----
// pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor
// depends on ddm_pkg
module ddm_div import ddm_pkg::*; #(
	parameter int LIMIT = 255
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [2*$clog2(LIMIT+1):0]             in_num_l,
	input  logic [2*$clog2(LIMIT+1):0]             in_num_r,
	input  logic [$clog2(LIMIT+1):0]               in_den,
	input  side_t                                  in_side,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [$clog2(LIMIT+1)-1:0]             out_quo_l,
	output logic [$clog2(LIMIT+1)-1:0]             out_quo_r,
	output side_t                                  out_side
);

	localparam int QW = $clog2(LIMIT + 1);
	localparam int DW = QW + 1;
	localparam int NW = QW + DW;

	logic          vld_s  [1:QW];
	logic          rdy    [1:QW];
	logic [DW-1:0] rem_l_s[1:QW];
	logic [DW-1:0] rem_r_s[1:QW];
	logic [QW-1:0] lo_l_s [1:QW];
	logic [QW-1:0] lo_r_s [1:QW];
	logic [QW-1:0] q_l_s  [1:QW];
	logic [QW-1:0] q_r_s  [1:QW];
	logic [DW-1:0] den_s  [1:QW];
	side_t         side_s [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic          cur_vld;
		logic [DW-1:0] cur_rem_l, cur_rem_r, cur_den;
		logic [QW-1:0] cur_lo_l, cur_lo_r, cur_q_l, cur_q_r;
		side_t         cur_side;
		logic [DW:0]   t_l, t_r;
		logic          ge_l, ge_r;

		if (k == 0) begin : g_in
			assign cur_vld   = in_valid;
			assign cur_rem_l = in_num_l[NW-1:QW];
			assign cur_rem_r = in_num_r[NW-1:QW];
			assign cur_lo_l  = in_num_l[QW-1:0];
			assign cur_lo_r  = in_num_r[QW-1:0];
			assign cur_q_l   = '0;
			assign cur_q_r   = '0;
			assign cur_den   = in_den;
			assign cur_side  = in_side;
		end else begin : g_mid
			assign cur_vld   = vld_s[k];
			assign cur_rem_l = rem_l_s[k];
			assign cur_rem_r = rem_r_s[k];
			assign cur_lo_l  = lo_l_s[k];
			assign cur_lo_r  = lo_r_s[k];
			assign cur_q_l   = q_l_s[k];
			assign cur_q_r   = q_r_s[k];
			assign cur_den   = den_s[k];
			assign cur_side  = side_s[k];
		end

		if (k == QW - 1) begin : g_rdy_last
			assign rdy[k+1] = !vld_s[k+1] || out_ready;
		end else begin : g_rdy_mid
			assign rdy[k+1] = !vld_s[k+1] || rdy[k+2];
		end

		// bring down the next numerator bit and try the subtract
		assign t_l  = {cur_rem_l, cur_lo_l[QW-1]};
		assign t_r  = {cur_rem_r, cur_lo_r[QW-1]};
		assign ge_l = t_l >= {1'b0, cur_den};
		assign ge_r = t_r >= {1'b0, cur_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (rdy[k+1]) begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (cur_vld && rdy[k+1]) begin
				rem_l_s[k+1] <= ge_l ? DW'(t_l - {1'b0, cur_den}) : DW'(t_l);
				rem_r_s[k+1] <= ge_r ? DW'(t_r - {1'b0, cur_den}) : DW'(t_r);
				lo_l_s[k+1]  <= cur_lo_l << 1;
				lo_r_s[k+1]  <= cur_lo_r << 1;
				q_l_s[k+1]   <= QW'({cur_q_l, ge_l});
				q_r_s[k+1]   <= QW'({cur_q_r, ge_r});
				den_s[k+1]   <= cur_den;
				side_s[k+1]  <= cur_side;
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_s[QW];
	assign out_quo_l = q_l_s[QW];
	assign out_quo_r = q_r_s[QW];
	assign out_side  = side_s[QW];

	// a scaled result never leaves a remainder as large as the divisor
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[QW] && !side_s[QW].byp) |->
			(rem_l_s[QW] < den_s[QW]) && (rem_r_s[QW] < den_s[QW]))
		else $error("divider remainder not below divisor");

	a_quo_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[QW] && !side_s[QW].byp) |->
			(q_l_s[QW] <= QW'(LIMIT)) && (q_r_s[QW] <= QW'(LIMIT)))
		else $error("scaled drive exceeds limit");

endmodule

// ----- src/differential_drive_mixer.sv -----
// differential drive mixer, pipelined from input transaction to output valid through
// clamp/mix, magnitude/max, constant multiply, one divider stage per quotient bit,
// then the output register. Stages stall independently so bubbles fill.
// throughput is one transaction per cycle when the output is not back-pressured.
// reset clears only the valid bits; no item state survives between transactions.
module differential_drive_mixer import ddm_pkg::*; #(
	parameter int OUTPUT_LIMIT = 255
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // velocity_cmd[15:0], turn_cmd[31:16]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // left_drive[8:0], right_drive[17:9], zeros
);

	localparam int LW = $clog2(OUTPUT_LIMIT + 1);
	localparam int SW = LW + 1;
	localparam int XW = SW + 1;
	localparam int NW = SW + LW;
	localparam logic signed [CMD_W-1:0] LIM_P = CMD_W'(OUTPUT_LIMIT);
	localparam logic signed [CMD_W-1:0] LIM_N = -LIM_P;
	localparam logic signed [DRV_W:0]   LIM_D = (DRV_W+1)'(OUTPUT_LIMIT);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	logic div_in_ready, div_out_valid, div_out_ready;

	// stage 1: clamp and mix
	logic signed [CMD_W-1:0] vel_in, trn_in, vel_c, trn_c;
	logic signed [CMD_W:0]   lsum, rsum;
	logic signed [XW-1:0]    left_s1, right_s1;

	assign vel_in = s_tdata[CMD_W-1:0];
	assign trn_in = s_tdata[2*CMD_W-1:CMD_W];
	assign vel_c  = (vel_in > LIM_P) ? LIM_P : ((vel_in < LIM_N) ? LIM_N : vel_in);
	assign trn_c  = (trn_in > LIM_P) ? LIM_P : ((trn_in < LIM_N) ? LIM_N : trn_in);
	assign lsum   = (CMD_W+1)'(vel_c) - (CMD_W+1)'(trn_c);
	assign rsum   = (CMD_W+1)'(vel_c) + (CMD_W+1)'(trn_c);

	// stage 2: magnitudes and their max
	logic signed [XW-1:0] abs_l, abs_r;
	logic [SW-1:0]        mag_l, mag_r, mag_max;
	logic [SW-1:0]        mag_l_s2, mag_r_s2, den_s2;
	side_t                side_s2;

	assign abs_l   = left_s1[XW-1] ? -left_s1 : left_s1;
	assign abs_r   = right_s1[XW-1] ? -right_s1 : right_s1;
	assign mag_l   = abs_l[SW-1:0];
	assign mag_r   = abs_r[SW-1:0];
	assign mag_max = (mag_l > mag_r) ? mag_l : mag_r;

	// stage 3: numerators scaled by the limit
	logic [NW-1:0] num_l_s3, num_r_s3;
	logic [SW-1:0] den_s3;
	side_t         side_s3;

	assign rdy1     = !v_s1 || rdy2;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy3     = !v_s3 || div_in_ready;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && rdy1) begin
			left_s1  <= lsum[XW-1:0];
			right_s1 <= rsum[XW-1:0];
		end
		if (v_s1 && rdy2) begin
			mag_l_s2      <= mag_l;
			mag_r_s2      <= mag_r;
			den_s2        <= mag_max;
			side_s2.byp   <= mag_max <= SW'(OUTPUT_LIMIT);
			side_s2.neg_l <= left_s1[XW-1];
			side_s2.neg_r <= right_s1[XW-1];
			side_s2.raw_l <= DRV_W'(left_s1);
			side_s2.raw_r <= DRV_W'(right_s1);
		end
		if (v_s2 && rdy3) begin
			num_l_s3 <= NW'(mag_l_s2) * NW'(OUTPUT_LIMIT);
			num_r_s3 <= NW'(mag_r_s2) * NW'(OUTPUT_LIMIT);
			den_s3   <= den_s2;
			side_s3  <= side_s2;
		end
	end

	logic [LW-1:0] quo_l, quo_r;
	side_t         side_d;

	ddm_div #(
		.LIMIT(OUTPUT_LIMIT)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.in_ready (div_in_ready),
		.in_num_l (num_l_s3),
		.in_num_r (num_r_s3),
		.in_den   (den_s3),
		.in_side  (side_s3),
		.out_valid(div_out_valid),
		.out_ready(div_out_ready),
		.out_quo_l(quo_l),
		.out_quo_r(quo_r),
		.out_side (side_d)
	);

	// output register: sign back on, pick scaled or raw
	logic signed [LW:0]    qs_l, qs_r;
	logic [DRV_W-1:0]      drv_l, drv_r;
	logic                  m_tvalid_q;
	logic [DRV_W-1:0]      left_q, right_q;

	assign qs_l  = side_d.neg_l ? -$signed({1'b0, quo_l}) : $signed({1'b0, quo_l});
	assign qs_r  = side_d.neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
	assign drv_l = side_d.byp ? side_d.raw_l : DRV_W'(qs_l);
	assign drv_r = side_d.byp ? side_d.raw_r : DRV_W'(qs_r);

	assign div_out_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (div_out_ready) begin
			m_tvalid_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_out_valid && div_out_ready) begin
			left_q  <= drv_l;
			right_q <= drv_r;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W - 2*DRV_W)'(0), right_q, left_q};

	// input only backs up when every stage is full behind a blocked output
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && v_s1 && v_s2 && v_s3))
		else $error("input stalled with room in the pipeline");

	a_drive_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (OUTPUT_LIMIT > 255) ||
			(($signed({left_q[DRV_W-1], left_q}) <= LIM_D) &&
			 ($signed({left_q[DRV_W-1], left_q}) >= -LIM_D) &&
			 ($signed({right_q[DRV_W-1], right_q}) <= LIM_D) &&
			 ($signed({right_q[DRV_W-1], right_q}) >= -LIM_D)))
		else $error("wheel target outside output limit");

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for differential_drive_mixer: drives velocity/turn commands on the
// input stream, predicts both wheel targets and compares them with the output stream
// depends on src/ddm_pkg.sv, src/ddm_div.sv and src/differential_drive_mixer.sv
module testbench;
	import ddm_pkg::*;

	localparam int DRIVE_LIMIT = 255;
	localparam int DRAIN_CYCLES = 30;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [DRV_W-1:0] left;
		logic [DRV_W-1:0] right;
	} drive_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	drive_t pending_drive[$];
	int     mismatches;
	int     cycle_count;
	int     src_idle_pct;
	int     sink_stall_pct;

	differential_drive_mixer #(.OUTPUT_LIMIT(DRIVE_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp_cmd(logic signed [CMD_W-1:0] cmd);
		int x;
		x = int'(cmd);
		if (x > DRIVE_LIMIT)
			return DRIVE_LIMIT;
		if (x < -DRIVE_LIMIT)
			return -DRIVE_LIMIT;
		return x;
	endfunction

	function automatic drive_t mix_drive(logic signed [CMD_W-1:0] vel_cmd,
			logic signed [CMD_W-1:0] turn_cmd);
		int vel, trn, left, right, mag_l, mag_r, peak;
		drive_t d;
		vel = clamp_cmd(vel_cmd);
		trn = clamp_cmd(turn_cmd);
		left = vel - trn;
		right = vel + trn;
		mag_l = (left < 0) ? -left : left;
		mag_r = (right < 0) ? -right : right;
		peak = (mag_l > mag_r) ? mag_l : mag_r;
		// signed int division truncates toward zero
		if (peak > DRIVE_LIMIT) begin
			left = (left * DRIVE_LIMIT) / peak;
			right = (right * DRIVE_LIMIT) / peak;
		end
		d.left = left[DRV_W-1:0];
		d.right = right[DRV_W-1:0];
		return d;
	endfunction

	task automatic send_command(input logic signed [CMD_W-1:0] vel_cmd,
			input logic signed [CMD_W-1:0] turn_cmd);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= S_TDATA_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {turn_cmd, vel_cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_drive.push_back(mix_drive(vel_cmd, turn_cmd));
	endtask

	// values around the clamp and scale boundaries
	function automatic logic signed [CMD_W-1:0] edge_cmd();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return CMD_W'(DRIVE_LIMIT + int'($urandom_range(2)) - 1);
			3: return CMD_W'(-DRIVE_LIMIT - int'($urandom_range(2)) + 1);
			4: return '0;
			5: return CMD_W'(int'($urandom_range(6)) - 3);
			6: return CMD_W'(DRIVE_LIMIT / 2 + int'($urandom_range(2)) - 1);
			default: return CMD_W'(-DRIVE_LIMIT / 2 - int'($urandom_range(2)) + 1);
		endcase
	endfunction

	function automatic logic signed [CMD_W-1:0] in_range_cmd();
		return CMD_W'(int'($urandom_range(2 * DRIVE_LIMIT)) - DRIVE_LIMIT);
	endfunction

	task automatic test_corner_commands();
		send_command(16'sd0, 16'sd0);
		send_command(16'sh7fff, 16'sh7fff);
		send_command(16'sh8000, 16'sh8000);
		send_command(16'sh7fff, 16'sh8000);
		send_command(16'sh8000, 16'sh7fff);
		send_command(16'sd255, 16'sd0);
		send_command(-16'sd255, 16'sd0);
		send_command(16'sd0, 16'sd255);
		send_command(16'sd0, -16'sd255);
		send_command(16'sd256, 16'sd0);
		send_command(-16'sd256, 16'sd0);
		send_command(16'sd255, 16'sd255);
		send_command(16'sd128, 16'sd127);
		send_command(16'sd128, 16'sd128);
		send_command(-16'sd1, -16'sd1);
		send_command(16'sd1, -16'sd1);
		send_command(16'sd100, -16'sd50);
		send_command(-16'sd200, 16'sd100);
		send_command(16'sd7, -16'sd300);
		send_command(16'sh5555, 16'shaaaa);
		send_command(16'shaaaa, 16'sh5555);
	endtask

	task automatic test_random_commands(input int count, input int src_pct, input int sink_pct);
		logic signed [CMD_W-1:0] vel, trn;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		repeat (count) begin
			case ($urandom_range(3))
				0: begin
					vel = CMD_W'($urandom);
					trn = CMD_W'($urandom);
				end
				1: begin
					vel = in_range_cmd();
					trn = in_range_cmd();
				end
				2: begin
					vel = edge_cmd();
					trn = edge_cmd();
				end
				default: begin
					vel = $urandom_range(1) ? edge_cmd() : CMD_W'($urandom);
					trn = in_range_cmd();
				end
			endcase
			send_command(vel, trn);
		end
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		drive_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_drive.size() == 0) begin
				$error("unexpected result transaction: left_drive %0d right_drive %0d",
					$signed(m_tdata[DRV_W-1:0]), $signed(m_tdata[2*DRV_W-1:DRV_W]));
				mismatches++;
			end else begin
				want = pending_drive.pop_front();
				if (m_tdata[DRV_W-1:0] !== want.left) begin
					$error("left_drive expected %0d actual %0d",
						$signed(want.left), $signed(m_tdata[DRV_W-1:0]));
					mismatches++;
				end
				if (m_tdata[2*DRV_W-1:DRV_W] !== want.right) begin
					$error("right_drive expected %0d actual %0d",
						$signed(want.right), $signed(m_tdata[2*DRV_W-1:DRV_W]));
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		mismatches = 0;
		cycle_count = 0;
		src_idle_pct = 9;
		sink_stall_pct = 58;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_commands();
		test_random_commands(540, 9, 58);
		test_random_commands(540, 58, 9);
		test_random_commands(550, 0, 0);
		s_tvalid <= 1'b0;

		while (pending_drive.size() != 0)
			@(posedge clk);
		// catch any stray transaction still in the pipeline
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
